// ===== hw/rtl/dcm_pkg.sv =====
// Shared types, constants and the step microcode of the DC motor model.
`default_nettype none
package dcm_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned CFG_W    = 31;
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned REG_IDX_W = 3;

    localparam logic [DATA_W-1:0] FX_ONE = 32'h0001_0000;
    localparam logic [DATA_W-1:0] FX_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] FX_MIN = 32'h8000_0000;

    localparam logic [CFG_W-1:0] EM_FACTOR_RST       = 31'd131072;
    localparam logic [CFG_W-1:0] INDUCTANCE_RST      = 31'd6554;
    localparam logic [CFG_W-1:0] RESISTANCE_RST      = 31'd65536;
    localparam logic [CFG_W-1:0] MECH_TIME_CONST_RST = 31'd6554;
    localparam logic [CFG_W-1:0] REDUCTION_RATIO_RST = 31'd65536;
    localparam logic [CFG_W-1:0] STEP_RATE_RST       = 31'd65536000;

    localparam logic [REG_IDX_W-1:0] REG_EM_FACTOR       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INDUCTANCE      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RESISTANCE      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MECH_TIME_CONST = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_REDUCTION_RATIO = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_STEP_RATE       = 3'd5;

    localparam int unsigned DIV_BITS  = 48;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_BITS);

    localparam int unsigned NUM_UOPS = 20;
    localparam int unsigned UOP_W    = $clog2(NUM_UOPS);

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [3:0] {
        SRC_VOLT,
        SRC_BEMF,
        SRC_CUR,
        SRC_ANGLE,
        SRC_LOAD,
        SRC_ONE,
        SRC_EMF,
        SRC_IND,
        SRC_RES,
        SRC_MTC,
        SRC_RR,
        SRC_SR,
        SRC_ACC,
        SRC_D1,
        SRC_T1,
        SRC_SPEED
    } t_src;

    typedef enum logic [2:0] {
        DST_ACC,
        DST_D1,
        DST_T1,
        DST_CUR,
        DST_BEMF,
        DST_ANGLE,
        DST_SPEED,
        DST_MOMENT
    } t_dst;

    typedef struct packed {
        t_op  op;
        t_src src_a;
        t_src src_b;
        t_dst dst;
    } t_uop;

    typedef struct packed {
        logic              start;
        t_op               op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } t_alu_rsp;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_ISSUE,
        SEQ_WAIT,
        SEQ_FINISH
    } t_seq_state;

    typedef enum logic [2:0] {
        ALU_IDLE,
        ALU_MUL,
        ALU_DIV,
        ALU_SAT,
        ALU_DONE
    } t_alu_state;

    // One Euler step of the motor, one operation per entry.
    function automatic t_uop uop_rom(input logic [UOP_W-1:0] idx);
        t_uop u;
        case (idx)
            5'd0:    u = '{OP_MUL, SRC_SR,    SRC_IND,   DST_D1};
            5'd1:    u = '{OP_SUB, SRC_VOLT,  SRC_BEMF,  DST_ACC};
            5'd2:    u = '{OP_MUL, SRC_ACC,   SRC_RES,   DST_ACC};
            5'd3:    u = '{OP_DIV, SRC_ACC,   SRC_D1,    DST_T1};
            5'd4:    u = '{OP_DIV, SRC_RES,   SRC_D1,    DST_ACC};
            5'd5:    u = '{OP_SUB, SRC_ONE,   SRC_ACC,   DST_ACC};
            5'd6:    u = '{OP_MUL, SRC_ACC,   SRC_CUR,   DST_ACC};
            5'd7:    u = '{OP_ADD, SRC_T1,    SRC_ACC,   DST_CUR};
            5'd8:    u = '{OP_MUL, SRC_LOAD,  SRC_RES,   DST_ACC};
            5'd9:    u = '{OP_DIV, SRC_ACC,   SRC_EMF,   DST_ACC};
            5'd10:   u = '{OP_SUB, SRC_CUR,   SRC_ACC,   DST_T1};
            5'd11:   u = '{OP_MUL, SRC_SR,    SRC_MTC,   DST_ACC};
            5'd12:   u = '{OP_DIV, SRC_T1,    SRC_ACC,   DST_ACC};
            5'd13:   u = '{OP_ADD, SRC_BEMF,  SRC_ACC,   DST_BEMF};
            5'd14:   u = '{OP_DIV, SRC_BEMF,  SRC_EMF,   DST_SPEED};
            5'd15:   u = '{OP_MUL, SRC_RR,    SRC_SR,    DST_ACC};
            5'd16:   u = '{OP_DIV, SRC_SPEED, SRC_ACC,   DST_ACC};
            5'd17:   u = '{OP_ADD, SRC_ANGLE, SRC_ACC,   DST_ANGLE};
            5'd18:   u = '{OP_MUL, SRC_CUR,   SRC_EMF,   DST_ACC};
            5'd19:   u = '{OP_DIV, SRC_ACC,   SRC_RES,   DST_MOMENT};
            default: u = '{OP_ADD, SRC_ACC,   SRC_ACC,   DST_ACC};
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dcm_alu.sv =====
// Shared Q16.16 arithmetic unit: saturating add, subtract, multiply and bit-serial divide.
`default_nettype none
module dcm_alu (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  dcm_pkg::t_alu_req  i_req,
    output dcm_pkg::t_alu_rsp  o_rsp
);

    dcm_pkg::t_alu_state r_state, n_state;

    logic [dcm_pkg::DATA_W-1:0]    r_res, n_res;
    logic signed [63:0]            r_prod, n_prod;
    logic [dcm_pkg::DIV_BITS-1:0]  r_quo, n_quo;
    logic [dcm_pkg::DATA_W-1:0]    r_rem, n_rem;
    logic [dcm_pkg::DATA_W-1:0]    r_den, n_den;
    logic                          r_neg, n_neg;
    logic [dcm_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;

    logic [32:0]                  sum_ext;
    logic [47:0]                  prod_q;
    logic [32:0]                  trial;
    logic [32:0]                  diff;
    logic                         ge;
    logic [dcm_pkg::DATA_W-1:0]   abs_a;
    logic [dcm_pkg::DATA_W-1:0]   abs_b;

    function automatic logic [31:0] sat33(input logic [32:0] v);
        logic [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? dcm_pkg::FX_MIN : dcm_pkg::FX_MAX;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] sat48(input logic [47:0] v);
        logic [31:0] r;
        if (v[47:31] == 17'h0 || v[47:31] == 17'h1FFFF) begin
            r = v[31:0];
        end else begin
            r = v[47] ? dcm_pkg::FX_MIN : dcm_pkg::FX_MAX;
        end
        return r;
    endfunction

    always_comb begin
        if (i_req.op == dcm_pkg::OP_SUB) begin
            sum_ext = {i_req.a[31], i_req.a} - {i_req.b[31], i_req.b};
        end else begin
            sum_ext = {i_req.a[31], i_req.a} + {i_req.b[31], i_req.b};
        end
        prod_q = r_prod[63:16] + {47'd0, (r_prod[63] && (r_prod[15:0] != 16'd0))};
        trial  = {r_rem, r_quo[dcm_pkg::DIV_BITS-1]};
        diff   = trial - {1'b0, r_den};
        ge     = (trial >= {1'b0, r_den});
        abs_a  = i_req.a[31] ? (~i_req.a + 32'd1) : i_req.a;
        abs_b  = i_req.b[31] ? (~i_req.b + 32'd1) : i_req.b;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dcm_pkg::ALU_IDLE: begin
                if (i_req.start) begin
                    case (i_req.op)
                        dcm_pkg::OP_MUL: n_state = dcm_pkg::ALU_MUL;
                        dcm_pkg::OP_DIV: begin
                            n_state = (i_req.b == '0) ? dcm_pkg::ALU_DONE : dcm_pkg::ALU_DIV;
                        end
                        default:         n_state = dcm_pkg::ALU_DONE;
                    endcase
                end
            end
            dcm_pkg::ALU_MUL:  n_state = dcm_pkg::ALU_DONE;
            dcm_pkg::ALU_DIV: begin
                if (r_cnt == '0) begin
                    n_state = dcm_pkg::ALU_SAT;
                end
            end
            dcm_pkg::ALU_SAT:  n_state = dcm_pkg::ALU_DONE;
            dcm_pkg::ALU_DONE: n_state = dcm_pkg::ALU_IDLE;
            default:           n_state = dcm_pkg::ALU_IDLE;
        endcase
    end

    always_comb begin
        o_rsp.done   = (r_state == dcm_pkg::ALU_DONE);
        o_rsp.result = r_res;
    end

    always_comb begin
        n_res  = r_res;
        n_prod = r_prod;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        case (r_state)
            dcm_pkg::ALU_IDLE: begin
                if (i_req.start) begin
                    case (i_req.op)
                        dcm_pkg::OP_MUL: begin
                            n_prod = $signed(i_req.a) * $signed(i_req.b);
                        end
                        dcm_pkg::OP_DIV: begin
                            if (i_req.a == '0) begin
                                n_res = '0;
                            end else begin
                                n_res = i_req.a[31] ? dcm_pkg::FX_MIN : dcm_pkg::FX_MAX;
                            end
                            n_quo = {abs_a, 16'd0};
                            n_rem = '0;
                            n_den = abs_b;
                            n_neg = i_req.a[31] ^ i_req.b[31];
                            n_cnt = dcm_pkg::DIV_CNT_W'(dcm_pkg::DIV_BITS - 1);
                        end
                        default: n_res = sat33(sum_ext);
                    endcase
                end
            end
            dcm_pkg::ALU_MUL: n_res = sat48(prod_q);
            dcm_pkg::ALU_DIV: begin
                n_rem = ge ? diff[31:0] : trial[31:0];
                n_quo = {r_quo[dcm_pkg::DIV_BITS-2:0], ge};
                n_cnt = r_cnt - 1'b1;
            end
            dcm_pkg::ALU_SAT: begin
                if (r_neg) begin
                    n_res = (r_quo > 48'h0000_8000_0000) ? dcm_pkg::FX_MIN
                                                         : (~r_quo[31:0] + 32'd1);
                end else begin
                    n_res = (r_quo > 48'h0000_7FFF_FFFF) ? dcm_pkg::FX_MAX : r_quo[31:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dcm_pkg::ALU_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_prod <= n_prod;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_neg  <= n_neg;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/dc_motor_model_step_top.sv =====
// Top level of the DC motor model: register port, step sequencer and model state.
//
// Each input transaction is one simulation tick: a supply voltage and a load moment,
// or a request to reuse the held load moment. The block runs one Euler step of the
// motor and returns one output transaction with moment, shaft angle and angular speed.
// A tick takes 20 operations on one shared arithmetic unit. Divides are bit-serial,
// the divider producing one quotient bit per cycle; a divide by zero skips the
// bit-serial loop. The input side stalls for the whole tick; a finished result
// sits in an output register, and the next tick is accepted while it waits. If the
// receiver stalls, the following tick completes its arithmetic and then holds until
// the earlier result is taken. Reset clears the motor state and the held load
// moment and loads the default parameters. Parameters must be written through the
// register port only while the block is idle; the block itself does not enforce it.
`default_nettype none
module dc_motor_model_step_top (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire signed [dcm_pkg::DATA_W-1:0]   i_voltage,
    input  wire signed [dcm_pkg::DATA_W-1:0]   i_load_moment,
    input  wire                                i_use_held_load,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic signed [dcm_pkg::DATA_W-1:0]  o_moment,
    output logic signed [dcm_pkg::DATA_W-1:0]  o_angle,
    output logic signed [dcm_pkg::DATA_W-1:0]  o_angular_speed,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [dcm_pkg::ADDR_W-1:0]         paddr,
    input  wire  [dcm_pkg::DATA_W-1:0]         pwdata,
    output logic [dcm_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);

    dcm_pkg::t_seq_state r_state, n_state;

    logic [dcm_pkg::CFG_W-1:0] r_em_factor;
    logic [dcm_pkg::CFG_W-1:0] r_inductance;
    logic [dcm_pkg::CFG_W-1:0] r_resistance;
    logic [dcm_pkg::CFG_W-1:0] r_mech_time_const;
    logic [dcm_pkg::CFG_W-1:0] r_reduction_ratio;
    logic [dcm_pkg::CFG_W-1:0] r_step_rate;

    logic [dcm_pkg::DATA_W-1:0] r_cur;
    logic [dcm_pkg::DATA_W-1:0] r_bemf;
    logic [dcm_pkg::DATA_W-1:0] r_angle;
    logic [dcm_pkg::DATA_W-1:0] r_held;
    logic [dcm_pkg::DATA_W-1:0] r_volt;
    logic [dcm_pkg::DATA_W-1:0] r_acc;
    logic [dcm_pkg::DATA_W-1:0] r_d1;
    logic [dcm_pkg::DATA_W-1:0] r_t1;
    logic [dcm_pkg::DATA_W-1:0] r_speed;
    logic [dcm_pkg::DATA_W-1:0] r_moment;

    logic                       r_out_valid, n_out_valid;
    logic [dcm_pkg::DATA_W-1:0] r_out_moment;
    logic [dcm_pkg::DATA_W-1:0] r_out_angle;
    logic [dcm_pkg::DATA_W-1:0] r_out_speed;

    logic [dcm_pkg::UOP_W-1:0]  r_step;

    dcm_pkg::t_uop     uop;
    dcm_pkg::t_alu_req alu_req;
    dcm_pkg::t_alu_rsp alu_rsp;

    logic                          in_accept;
    logic                          out_accept;
    logic                          out_load;
    logic                          last_step;
    logic                          cfg_write;
    logic [dcm_pkg::REG_IDX_W-1:0] reg_idx;
    logic [dcm_pkg::DATA_W-1:0]    opnd_a;
    logic [dcm_pkg::DATA_W-1:0]    opnd_b;

    function automatic logic [31:0] pick(
        input dcm_pkg::t_src s,
        input logic [31:0]   volt, bemf, cur, angle, load, acc, d1, t1, speed,
        input logic [30:0]   emf, ind, res, mtc, rr, sr
    );
        logic [31:0] v;
        case (s)
            dcm_pkg::SRC_VOLT:  v = volt;
            dcm_pkg::SRC_BEMF:  v = bemf;
            dcm_pkg::SRC_CUR:   v = cur;
            dcm_pkg::SRC_ANGLE: v = angle;
            dcm_pkg::SRC_LOAD:  v = load;
            dcm_pkg::SRC_ONE:   v = dcm_pkg::FX_ONE;
            dcm_pkg::SRC_EMF:   v = {1'b0, emf};
            dcm_pkg::SRC_IND:   v = {1'b0, ind};
            dcm_pkg::SRC_RES:   v = {1'b0, res};
            dcm_pkg::SRC_MTC:   v = {1'b0, mtc};
            dcm_pkg::SRC_RR:    v = {1'b0, rr};
            dcm_pkg::SRC_SR:    v = {1'b0, sr};
            dcm_pkg::SRC_ACC:   v = acc;
            dcm_pkg::SRC_D1:    v = d1;
            dcm_pkg::SRC_T1:    v = t1;
            dcm_pkg::SRC_SPEED: v = speed;
            default:            v = acc;
        endcase
        return v;
    endfunction

    always_comb begin
        uop       = dcm_pkg::uop_rom(r_step);
        last_step = (r_step == dcm_pkg::UOP_W'(dcm_pkg::NUM_UOPS - 1));
        opnd_a    = pick(uop.src_a, r_volt, r_bemf, r_cur, r_angle, r_held, r_acc, r_d1,
                         r_t1, r_speed, r_em_factor, r_inductance, r_resistance,
                         r_mech_time_const, r_reduction_ratio, r_step_rate);
        opnd_b    = pick(uop.src_b, r_volt, r_bemf, r_cur, r_angle, r_held, r_acc, r_d1,
                         r_t1, r_speed, r_em_factor, r_inductance, r_resistance,
                         r_mech_time_const, r_reduction_ratio, r_step_rate);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dcm_pkg::SEQ_IDLE: begin
                if (i_in_valid) begin
                    n_state = dcm_pkg::SEQ_ISSUE;
                end
            end
            dcm_pkg::SEQ_ISSUE: n_state = dcm_pkg::SEQ_WAIT;
            dcm_pkg::SEQ_WAIT: begin
                if (alu_rsp.done) begin
                    n_state = last_step ? dcm_pkg::SEQ_FINISH : dcm_pkg::SEQ_ISSUE;
                end
            end
            dcm_pkg::SEQ_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = dcm_pkg::SEQ_IDLE;
                end
            end
            default: n_state = dcm_pkg::SEQ_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall    = (r_state != dcm_pkg::SEQ_IDLE);
        alu_req.start = (r_state == dcm_pkg::SEQ_ISSUE);
        alu_req.op    = uop.op;
        alu_req.a     = opnd_a;
        alu_req.b     = opnd_b;
        out_load      = (r_state == dcm_pkg::SEQ_FINISH) && (!r_out_valid || !i_out_stall);
    end

    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_accept = r_out_valid && !i_out_stall;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign reg_idx    = paddr[dcm_pkg::ADDR_W-1:2];
    assign pready     = 1'b1;

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (out_accept) begin
            n_out_valid = 1'b0;
        end
    end

    always_comb begin
        case (reg_idx)
            dcm_pkg::REG_EM_FACTOR:       prdata = {1'b0, r_em_factor};
            dcm_pkg::REG_INDUCTANCE:      prdata = {1'b0, r_inductance};
            dcm_pkg::REG_RESISTANCE:      prdata = {1'b0, r_resistance};
            dcm_pkg::REG_MECH_TIME_CONST: prdata = {1'b0, r_mech_time_const};
            dcm_pkg::REG_REDUCTION_RATIO: prdata = {1'b0, r_reduction_ratio};
            dcm_pkg::REG_STEP_RATE:       prdata = {1'b0, r_step_rate};
            default:                      prdata = '0;
        endcase
    end

    dcm_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= dcm_pkg::SEQ_IDLE;
            r_out_valid       <= 1'b0;
            r_step            <= '0;
            r_cur             <= '0;
            r_bemf            <= '0;
            r_angle           <= '0;
            r_held            <= '0;
            r_em_factor       <= dcm_pkg::EM_FACTOR_RST;
            r_inductance      <= dcm_pkg::INDUCTANCE_RST;
            r_resistance      <= dcm_pkg::RESISTANCE_RST;
            r_mech_time_const <= dcm_pkg::MECH_TIME_CONST_RST;
            r_reduction_ratio <= dcm_pkg::REDUCTION_RATIO_RST;
            r_step_rate       <= dcm_pkg::STEP_RATE_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (cfg_write) begin
                case (reg_idx)
                    dcm_pkg::REG_EM_FACTOR:       r_em_factor       <= pwdata[30:0];
                    dcm_pkg::REG_INDUCTANCE:      r_inductance      <= pwdata[30:0];
                    dcm_pkg::REG_RESISTANCE:      r_resistance      <= pwdata[30:0];
                    dcm_pkg::REG_MECH_TIME_CONST: r_mech_time_const <= pwdata[30:0];
                    dcm_pkg::REG_REDUCTION_RATIO: r_reduction_ratio <= pwdata[30:0];
                    dcm_pkg::REG_STEP_RATE:       r_step_rate       <= pwdata[30:0];
                    default: begin
                    end
                endcase
            end
            if (in_accept) begin
                r_step <= '0;
                if (!i_use_held_load) begin
                    r_held <= i_load_moment;
                end
            end else if ((r_state == dcm_pkg::SEQ_WAIT) && alu_rsp.done) begin
                r_step <= r_step + 1'b1;
                case (uop.dst)
                    dcm_pkg::DST_CUR:   r_cur   <= alu_rsp.result;
                    dcm_pkg::DST_BEMF:  r_bemf  <= alu_rsp.result;
                    dcm_pkg::DST_ANGLE: r_angle <= alu_rsp.result;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_volt <= i_voltage;
        end
        if ((r_state == dcm_pkg::SEQ_WAIT) && alu_rsp.done) begin
            r_acc <= alu_rsp.result;
            case (uop.dst)
                dcm_pkg::DST_D1:     r_d1     <= alu_rsp.result;
                dcm_pkg::DST_T1:     r_t1     <= alu_rsp.result;
                dcm_pkg::DST_SPEED:  r_speed  <= alu_rsp.result;
                dcm_pkg::DST_MOMENT: r_moment <= alu_rsp.result;
                default: begin
                end
            endcase
        end
        if (out_load) begin
            r_out_moment <= r_moment;
            r_out_angle  <= r_angle;
            r_out_speed  <= r_speed;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_moment        = r_out_moment;
    assign o_angle         = r_out_angle;
    assign o_angular_speed = r_out_speed;

endmodule
`default_nettype wire

// ===== hw/rtl/dcm_step_chk.sv =====
// Port-level checker for the DC motor model and its bind to the top level.
`default_nettype none
module dcm_step_chk (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         i_in_valid,
    input wire                         o_in_stall,
    input wire                         o_out_valid,
    input wire                         i_out_stall,
    input wire [dcm_pkg::DATA_W-1:0]   o_moment,
    input wire [dcm_pkg::DATA_W-1:0]   o_angle,
    input wire [dcm_pkg::DATA_W-1:0]   o_angular_speed,
    input wire                         pready
);

    // An accepted transaction keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken twice in a row");

    // A new result only appears while a tick is being worked on.
    a_result_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared with no tick in progress");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_moment) && $stable(o_angle)
             && $stable(o_angular_speed)))
        else $error("stalled output changed");

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("register port not ready");

endmodule

bind dc_motor_model_step_top dcm_step_chk u_dcm_step_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_moment        (o_moment),
    .o_angle         (o_angle),
    .o_angular_speed (o_angular_speed),
    .pready          (pready)
);
`default_nettype wire
